@@ rtl/pnz_pkg.sv @@
// pnz_pkg: shared types and constants of the perlin noise sample unit
// no dependencies; used by the interfaces, pnz_front, pnz_back and the top level

package pnz_pkg;

   // command codes of one input transaction
   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_WRITE  = 1'b1
   } cmd_type;

   localparam int COORD_W    = 32;
   localparam int CELL_W     = 8;
   localparam int NOISE_W    = 18;
   localparam int PERM_DEPTH = 256;

   // gradient selection codes of the low hash nibble
   localparam logic [3:0] GRAD_SPLIT_P = 4'd8;
   localparam logic [3:0] GRAD_SPLIT_Q = 4'd4;
   localparam logic [3:0] GRAD_ALT_A   = 4'd12;
   localparam logic [3:0] GRAD_ALT_B   = 4'd14;

   // output clamp bounds, signed 18-bit range
   localparam logic signed [31:0] NOISE_MAX = 32'sd131071;
   localparam logic signed [31:0] NOISE_MIN = -32'sd131072;

   // decoded transaction held in the command queue
   typedef struct packed {
      cmd_type                    cmd;
      logic [COORD_W-1:0]         x_pos;
      logic [COORD_W-1:0]         y_pos;
      logic [COORD_W-1:0]         z_pos;
      logic [CELL_W-1:0]          table_index;
      logic [CELL_W-1:0]          table_value;
   } item_type;

   // back end status toward the front end and the top level
   typedef struct packed {
      logic init_done;
      logic out_overflow;
   } back_stat_type;

   // permutation bytes loaded by the clearing pass after reset
   localparam logic [7:0] PERM_RESET [PERM_DEPTH] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

endpackage

@@ rtl/pnz_if.sv @@
// pnz_if: valid/ready channel interfaces of the perlin noise sample unit
// depends on pnz_pkg for field widths

interface pnz_req_if;
   logic                                valid;
   logic                                ready;
   logic                                command;
   logic signed [pnz_pkg::COORD_W-1:0]  x_pos;
   logic signed [pnz_pkg::COORD_W-1:0]  y_pos;
   logic signed [pnz_pkg::COORD_W-1:0]  z_pos;
   logic [pnz_pkg::CELL_W-1:0]          table_index;
   logic [pnz_pkg::CELL_W-1:0]          table_value;

   modport source (output valid, command, x_pos, y_pos, z_pos, table_index, table_value,
                   input ready);
   modport sink (input valid, command, x_pos, y_pos, z_pos, table_index, table_value,
                 output ready);
endinterface

interface pnz_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [pnz_pkg::NOISE_W-1:0]  noise_value;

   modport source (output valid, noise_value, input ready);
   modport sink (input valid, noise_value, output ready);
endinterface

@@ rtl/pnz_ram.sv @@
// pnz_ram: generic single write, dual read ram with registered read data
// no dependencies

module pnz_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_a,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port and two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/pnz_fifo.sv @@
// pnz_fifo: small valid/ready queue with a register array
// no dependencies

module pnz_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   parameter int PTR_W = $clog2(DEPTH),
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/pnz_front.sv @@
// pnz_front: accepts request transactions, decodes the command, feeds the queue
// depends on pnz_pkg and pnz_if

module pnz_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   pnz_req_if.sink           req_bus,
   output logic              push_valid,
   input  logic              push_ready,
   output pnz_pkg::item_type push_data
);

   logic              hold_vld_ff, hold_vld_in;
   pnz_pkg::item_type hold_ff, item_in;
   logic              accept;

   assign req_bus.ready = enable && (!hold_vld_ff || push_ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_valid    = hold_vld_ff;
   assign push_data     = hold_ff;

   // decode: a write keeps only its table fields, a sample only its point
   always_comb begin
      item_in = '0;
      if (req_bus.command) begin
         item_in.cmd         = pnz_pkg::CMD_WRITE;
         item_in.table_index = req_bus.table_index;
         item_in.table_value = req_bus.table_value;
      end else begin
         item_in.cmd   = pnz_pkg::CMD_SAMPLE;
         item_in.x_pos = req_bus.x_pos;
         item_in.y_pos = req_bus.y_pos;
         item_in.z_pos = req_bus.z_pos;
      end
      hold_vld_in = accept || (hold_vld_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff <= item_in;
      end
   end

endmodule

@@ rtl/pnz_back.sv @@
// pnz_back: hash lookups, smoothing, gradient dots and trilinear blend pipeline
// depends on pnz_pkg, pnz_if, pnz_ram and pnz_fifo

module pnz_back #(
   parameter int FRAC_BITS = 16,
   parameter int OUT_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  pnz_pkg::item_type      q_data,
   output pnz_pkg::back_stat_type stat,
   pnz_rsp_if.source              rsp_bus
);

   localparam int F      = FRAC_BITS;
   localparam int OW     = F + 1;
   localparam int DW     = F + 3;
   localparam int DFW    = F + 4;
   localparam int QW     = F + 4;
   localparam int Q2W    = 2 * F + 4;
   localparam int MW     = 2 * F + 5;
   localparam int CW     = $clog2(OUT_DEPTH + 1);
   localparam int NS     = 14;
   localparam int CELL_W = pnz_pkg::CELL_W;
   localparam int NW     = pnz_pkg::NOISE_W;
   localparam logic [CELL_W-1:0] PERM_LAST = CELL_W'(pnz_pkg::PERM_DEPTH - 1);

   // gradient dot of improved noise, chosen by the low hash nibble
   function automatic logic signed [DW-1:0] grad_dot(
      input logic [CELL_W-1:0]    hash,
      input logic signed [OW-1:0] dx,
      input logic signed [OW-1:0] dy,
      input logic signed [OW-1:0] dz
   );
      logic [3:0]           h;
      logic signed [DW-1:0] p, q;
      h = hash[3:0];
      p = (h < pnz_pkg::GRAD_SPLIT_P) ? DW'(dx) : DW'(dy);
      if (h < pnz_pkg::GRAD_SPLIT_Q) begin
         q = DW'(dy);
      end else if (h == pnz_pkg::GRAD_ALT_A || h == pnz_pkg::GRAD_ALT_B) begin
         q = DW'(dx);
      end else begin
         q = DW'(dz);
      end
      if (h[0]) begin
         p = -p;
      end
      if (h[1]) begin
         q = -q;
      end
      return p + q;
   endfunction

   // clearing pass and credit control
   logic              init_ff;
   logic [CELL_W-1:0] init_cnt_ff;
   logic [CW-1:0]     credit_ff, credit_in;
   logic              pop, pop_is_wr, rsp_fire;
   logic              out_ready;

   assign pop_is_wr = q_data.cmd == pnz_pkg::CMD_WRITE;
   assign q_ready   = !init_ff && (pop_is_wr || credit_ff < CW'(OUT_DEPTH));
   assign pop       = q_valid && q_ready;
   assign rsp_fire  = rsp_bus.valid && rsp_bus.ready;
   assign credit_in = credit_ff + CW'(pop && !pop_is_wr) - CW'(rsp_fire);

   // pipeline control
   logic              vld_ff [NS];
   logic              wr_ff  [3];
   logic [CELL_W-1:0] idx_ff [3];
   logic [CELL_W-1:0] val_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff     <= 1'b1;
         init_cnt_ff <= '0;
         credit_ff   <= '0;
         for (int k = 0; k < NS; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (init_ff) begin
            init_cnt_ff <= init_cnt_ff + 1'b1;
            if (init_cnt_ff == PERM_LAST) begin
               init_ff <= 1'b0;
            end
         end
         credit_ff <= credit_in;
         vld_ff[0] <= pop;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
         vld_ff[3] <= vld_ff[2] && !wr_ff[2];
         for (int k = 4; k < NS; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // stage 0: split coordinates into cells and fractions
   logic [pnz_pkg::COORD_W-1:0] coord [3];
   logic [CELL_W-1:0]           cell0_ff [3];
   logic [F-1:0]                frac0_ff [3];
   logic [F-1:0]                frac1_ff [3];
   logic [F-1:0]                frac2_ff [3];
   logic [F-1:0]                frac3_ff [3];
   logic [CELL_W-1:0]           cy1_ff, cz1_ff, cz2_ff;

   assign coord[0] = q_data.x_pos;
   assign coord[1] = q_data.y_pos;
   assign coord[2] = q_data.z_pos;

   always_ff @(posedge clock) begin
      wr_ff[0]  <= pop_is_wr;
      idx_ff[0] <= q_data.table_index;
      val_ff[0] <= q_data.table_value;
      wr_ff[1]  <= wr_ff[0];
      idx_ff[1] <= idx_ff[0];
      val_ff[1] <= val_ff[0];
      wr_ff[2]  <= wr_ff[1];
      idx_ff[2] <= idx_ff[1];
      val_ff[2] <= val_ff[1];
      for (int a = 0; a < 3; a++) begin
         cell0_ff[a] <= coord[a][F+CELL_W-1:F];
         frac0_ff[a] <= coord[a][F-1:0];
         frac1_ff[a] <= frac0_ff[a];
         frac2_ff[a] <= frac1_ff[a];
         frac3_ff[a] <= frac2_ff[a];
      end
      cy1_ff <= cell0_ff[1];
      cz1_ff <= cell0_ff[2];
      cz2_ff <= cz1_ff;
   end

   // table write port of each copy: clearing pass, then write transactions in order
   logic              ram_we [3];
   logic [CELL_W-1:0] ram_wa [3];
   logic [CELL_W-1:0] ram_wd [3];

   always_comb begin
      for (int s = 0; s < 3; s++) begin
         ram_we[s] = init_ff || (vld_ff[s] && wr_ff[s]);
         ram_wa[s] = init_ff ? init_cnt_ff : idx_ff[s];
         ram_wd[s] = init_ff ? pnz_pkg::PERM_RESET[init_cnt_ff] : val_ff[s];
      end
   end

   // hash level a: perm[xi], perm[xi+1]
   logic [CELL_W-1:0] ra_a, ra_b;

   pnz_ram #(.WIDTH(CELL_W), .DEPTH(pnz_pkg::PERM_DEPTH)) u_ram_a (
      .clock     (clock),
      .wr_en     (ram_we[0]),
      .wr_addr   (ram_wa[0]),
      .wr_data   (ram_wd[0]),
      .rd_addr_a (cell0_ff[0]),
      .rd_addr_b (cell0_ff[0] + 1'b1),
      .rd_data_a (ra_a),
      .rd_data_b (ra_b)
   );

   // hash level b: perm[ha], perm[ha+1], perm[hb], perm[hb+1]
   logic [CELL_W-1:0] hb_addr [2];
   logic [CELL_W-1:0] rb_a [2];
   logic [CELL_W-1:0] rb_b [2];

   assign hb_addr[0] = ra_a + cy1_ff;
   assign hb_addr[1] = ra_b + cy1_ff;

   // hash level c: the eight corner hashes
   logic [CELL_W-1:0] hc_addr [4];
   logic [CELL_W-1:0] rc_a [4];
   logic [CELL_W-1:0] rc_b [4];

   assign hc_addr[0] = rb_a[0] + cz2_ff;
   assign hc_addr[1] = rb_b[0] + cz2_ff;
   assign hc_addr[2] = rb_a[1] + cz2_ff;
   assign hc_addr[3] = rb_b[1] + cz2_ff;

   for (genvar g = 0; g < 2; g++) begin : g_ram_b
      pnz_ram #(.WIDTH(CELL_W), .DEPTH(pnz_pkg::PERM_DEPTH)) u_ram_b (
         .clock     (clock),
         .wr_en     (ram_we[1]),
         .wr_addr   (ram_wa[1]),
         .wr_data   (ram_wd[1]),
         .rd_addr_a (hb_addr[g]),
         .rd_addr_b (hb_addr[g] + 1'b1),
         .rd_data_a (rb_a[g]),
         .rd_data_b (rb_b[g])
      );
   end

   for (genvar g = 0; g < 4; g++) begin : g_ram_c
      pnz_ram #(.WIDTH(CELL_W), .DEPTH(pnz_pkg::PERM_DEPTH)) u_ram_c (
         .clock     (clock),
         .wr_en     (ram_we[2]),
         .wr_addr   (ram_wa[2]),
         .wr_data   (ram_wd[2]),
         .rd_addr_a (hc_addr[g]),
         .rd_addr_b (hc_addr[g] + 1'b1),
         .rd_data_a (rc_a[g]),
         .rd_data_b (rc_b[g])
      );
   end

   // smootherstep per axis, four stages beside the hash lookups
   logic [2*F-1:0] sq1_ff [3];
   logic [Q2W-1:0] q2_ff  [3];
   logic [F-1:0]   t2_ff  [3];
   logic [QW-1:0]  q3_ff  [3];
   logic [F-1:0]   t3_ff  [3];
   logic [F-1:0]   sm4_ff [3];
   logic [F-1:0]   s_dly_ff [7][3];
   logic [Q2W-1:0] q2_in  [3];
   logic [2*F-1:0] t3_prod [3];
   logic [QW+F-1:0] s_prod [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         // 6t^2 + 10 - 15t, all scaled to 2F fraction bits
         q2_in[a] = (Q2W'(sq1_ff[a]) << 2) + (Q2W'(sq1_ff[a]) << 1)
                  + (Q2W'(10) << (2 * F))
                  - (Q2W'(frac1_ff[a]) << (F + 4)) + (Q2W'(frac1_ff[a]) << F);
         t3_prod[a] = t2_ff[a] * frac2_ff[a];
         s_prod[a]  = t3_ff[a] * q3_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         sq1_ff[a] <= frac0_ff[a] * frac0_ff[a];
         q2_ff[a]  <= q2_in[a];
         t2_ff[a]  <= sq1_ff[a][2*F-1:F];
         q3_ff[a]  <= q2_ff[a][Q2W-1:F];
         t3_ff[a]  <= t3_prod[a][2*F-1:F];
         sm4_ff[a] <= s_prod[a][2*F-1:F];
         s_dly_ff[0][a] <= sm4_ff[a];
         for (int j = 1; j < 7; j++) begin
            s_dly_ff[j][a] <= s_dly_ff[j-1][a];
         end
      end
   end

   // stage 3: corner offsets and gradient dots
   logic signed [OW-1:0] fo [3];
   logic signed [OW-1:0] go [3];
   logic signed [DW-1:0] da_in [4];
   logic signed [DW-1:0] db_in [4];
   logic signed [DW-1:0] da_ff [4];
   logic signed [DW-1:0] db_ff [4];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         fo[a] = $signed({1'b0, frac3_ff[a]});
         go[a] = $signed({1'b1, frac3_ff[a]});
      end
      da_in[0] = grad_dot(rc_a[0], fo[0], fo[1], fo[2]);
      db_in[0] = grad_dot(rc_a[2], go[0], fo[1], fo[2]);
      da_in[1] = grad_dot(rc_a[1], fo[0], go[1], fo[2]);
      db_in[1] = grad_dot(rc_a[3], go[0], go[1], fo[2]);
      da_in[2] = grad_dot(rc_b[0], fo[0], fo[1], go[2]);
      db_in[2] = grad_dot(rc_b[2], go[0], fo[1], go[2]);
      da_in[3] = grad_dot(rc_b[1], fo[0], go[1], go[2]);
      db_in[3] = grad_dot(rc_b[3], go[0], go[1], go[2]);
   end

   // x blend: difference, multiply, add
   logic signed [DFW-1:0] dif5_ff [4];
   logic signed [DW-1:0]  a5_ff   [4];
   logic signed [MW-1:0]  prod6_ff [4];
   logic signed [DW-1:0]  a6_ff   [4];
   logic signed [DW-1:0]  l7_ff   [4];
   logic signed [F:0]     su, sv, sw;

   assign su = $signed({1'b0, s_dly_ff[0][0]});
   assign sv = $signed({1'b0, s_dly_ff[3][1]});
   assign sw = $signed({1'b0, s_dly_ff[6][2]});

   // y and z blends
   logic signed [DFW-1:0] d8_ff  [2];
   logic signed [DW-1:0]  a8_ff  [2];
   logic signed [MW-1:0]  prod9_ff [2];
   logic signed [DW-1:0]  a9_ff  [2];
   logic signed [DW-1:0]  m10_ff [2];
   logic signed [DFW-1:0] d11_ff;
   logic signed [DW-1:0]  a11_ff;
   logic signed [MW-1:0]  prod12_ff;
   logic signed [DW-1:0]  a12_ff;
   logic signed [DW-1:0]  n13_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         da_ff[i]    <= da_in[i];
         db_ff[i]    <= db_in[i];
         dif5_ff[i]  <= DFW'(db_ff[i]) - DFW'(da_ff[i]);
         a5_ff[i]    <= da_ff[i];
         prod6_ff[i] <= su * dif5_ff[i];
         a6_ff[i]    <= a5_ff[i];
         l7_ff[i]    <= DW'(MW'(a6_ff[i]) + (prod6_ff[i] >>> F));
      end
      for (int j = 0; j < 2; j++) begin
         d8_ff[j]    <= DFW'(l7_ff[2*j+1]) - DFW'(l7_ff[2*j]);
         a8_ff[j]    <= l7_ff[2*j];
         prod9_ff[j] <= sv * d8_ff[j];
         a9_ff[j]    <= a8_ff[j];
         m10_ff[j]   <= DW'(MW'(a9_ff[j]) + (prod9_ff[j] >>> F));
      end
      d11_ff    <= DFW'(m10_ff[1]) - DFW'(m10_ff[0]);
      a11_ff    <= m10_ff[0];
      prod12_ff <= sw * d11_ff;
      a12_ff    <= a11_ff;
      n13_ff    <= DW'(MW'(a12_ff) + (prod12_ff >>> F));
   end

   // clamp to the output range
   logic signed [31:0]   n_ext;
   logic signed [NW-1:0] noise_sat;

   always_comb begin
      n_ext = 32'(n13_ff);
      if (n_ext > pnz_pkg::NOISE_MAX) begin
         noise_sat = NW'(pnz_pkg::NOISE_MAX);
      end else if (n_ext < pnz_pkg::NOISE_MIN) begin
         noise_sat = NW'(pnz_pkg::NOISE_MIN);
      end else begin
         noise_sat = n_ext[NW-1:0];
      end
   end

   // result queue, sized by the credit count
   logic [NW-1:0] out_data;

   pnz_fifo #(.WIDTH(NW), .DEPTH(OUT_DEPTH)) u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (vld_ff[NS-1]),
      .push_ready (out_ready),
      .push_data  (noise_sat),
      .pop_valid  (rsp_bus.valid),
      .pop_ready  (rsp_bus.ready),
      .pop_data   (out_data)
   );

   assign rsp_bus.noise_value = $signed(out_data);
   assign stat.init_done      = !init_ff;
   assign stat.out_overflow   = vld_ff[NS-1] && !out_ready;

endmodule

@@ rtl/perlin_noise_3d_sample_unit.sv @@
// perlin_noise_3d_sample_unit: 3d improved gradient noise with a writable permutation table
// a sample passes the front register, command queue, 14-stage back pipeline and result queue
// one transaction per cycle, set by the back pipeline and 7 table copies, unless results back up
// reset: a clearing pass loads the 256 permutation bytes, req not ready until it is done
// write transactions give no result and take effect for all later samples
// depends on pnz_pkg, pnz_if, pnz_fifo, pnz_front and pnz_back

module perlin_noise_3d_sample_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   pnz_req_if.sink   req_bus,
   pnz_rsp_if.source rsp_bus
);

   localparam int QUEUE_DEPTH = 4;
   localparam int ITEM_W      = $bits(pnz_pkg::item_type);

   logic                   fq_push_valid, fq_push_ready;
   pnz_pkg::item_type      fq_push_data;
   logic                   fq_pop_valid, fq_pop_ready;
   logic [ITEM_W-1:0]      fq_pop_bits;
   pnz_pkg::item_type      fq_pop_data;
   pnz_pkg::back_stat_type stat;

   // front end: accept and decode
   pnz_front u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (stat.init_done),
      .req_bus    (req_bus),
      .push_valid (fq_push_valid),
      .push_ready (fq_push_ready),
      .push_data  (fq_push_data)
   );

   // command queue between front and back
   pnz_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_push_valid),
      .push_ready (fq_push_ready),
      .push_data  (fq_push_data),
      .pop_valid  (fq_pop_valid),
      .pop_ready  (fq_pop_ready),
      .pop_data   (fq_pop_bits)
   );

   assign fq_pop_data = pnz_pkg::item_type'(fq_pop_bits);

   // back end: noise pipeline and result queue
   pnz_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (fq_pop_valid),
      .q_ready (fq_pop_ready),
      .q_data  (fq_pop_data),
      .stat    (stat),
      .rsp_bus (rsp_bus)
   );

   // no transaction enters while the table is being loaded
   a_init_blocks_req: assert property (@(posedge clock) disable iff (reset)
      !stat.init_done |-> !req_bus.ready)
      else $error("request taken during table load");

   a_init_queue_empty: assert property (@(posedge clock) disable iff (reset)
      !stat.init_done |-> !fq_push_valid && !fq_pop_valid)
      else $error("queue active during table load");

   // credit accounting keeps the result queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !stat.out_overflow)
      else $error("result queue overflow");

   // reset restarts the table load
   a_reset_reloads: assert property (@(posedge clock)
      !reset && $past(reset) |-> !stat.init_done)
      else $error("table load skipped after reset");

endmodule
